[src/lruc_pkg.sv]
// ----------------------------------------------------------------------------
// lruc_pkg: shared types and constants for the LRU cache cost block
// Key folding, cost constants and the request/response bundles that pass
// between the stream shell and the cache core.
// ----------------------------------------------------------------------------
package lruc_pkg;

    localparam int KEY_W  = 64;
    localparam int COST_W = 32;
    localparam int CAP_W  = 5;

    localparam logic [COST_W-1:0] HIT_COST      = 32'd1;
    localparam logic [COST_W-1:0] MISS_COST     = 32'd5;
    localparam logic [CAP_W-1:0]  CAP_RESET_VAL = 5'd16;

    localparam logic [7:0] ASCII_UPPER_A = 8'h41;
    localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
    localparam logic [7:0] ASCII_CASE    = 8'h20;

    // one lookup request to the core
    typedef struct packed {
        logic             step;
        logic [KEY_W-1:0] key;
    } t_lruc_req;

    // registered lookup result
    typedef struct packed {
        logic              hit;
        logic [COST_W-1:0] cost;
    } t_lruc_rsp;

    // fold A-Z to a-z in every byte
    function automatic logic [KEY_W-1:0] fold_key(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] r;
        logic [7:0]       b;
        r = '0;
        for (int i = 0; i < KEY_W / 8; i++) begin
            b = k[8*i +: 8];
            if (b >= ASCII_UPPER_A && b <= ASCII_UPPER_Z) begin
                b = b + ASCII_CASE;
            end
            r[8*i +: 8] = b;
        end
        return r;
    endfunction

endpackage

[src/lruc_core.sv]
// ----------------------------------------------------------------------------
// lruc_core: fully associative LRU tag store and running cost
// Parallel tag compare, recency-rank update and victim pick are combinational;
// state and the result register update together on each step.
// ----------------------------------------------------------------------------
module lruc_core
    import lruc_pkg::*;
#(
    parameter int CAPACITY  = 16,
    parameter int KEY_BYTES = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_data,
    input  t_lruc_req        i_req,
    output t_lruc_rsp        o_rsp
);

    localparam int TW   = 8 * KEY_BYTES;
    localparam int RW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int FW   = $clog2(CAPACITY + 1);
    localparam int CMPW = 8;

    logic [TW-1:0]       r_tag  [CAPACITY];
    logic [RW-1:0]       r_rank [CAPACITY];
    logic [CAPACITY-1:0] r_valid;
    logic [FW-1:0]       r_fill;
    logic [CAP_W-1:0]    r_cap;
    logic                r_hit;
    logic [COST_W-1:0]   r_cost;

    logic [RW-1:0]       n_rank [CAPACITY];
    logic [CAPACITY-1:0] n_valid;
    logic [FW-1:0]       n_fill;
    logic [COST_W-1:0]   n_cost;

    logic [TW-1:0]       key;
    logic [CAPACITY-1:0] match;
    logic [CAPACITY-1:0] victim;
    logic [CAPACITY-1:0] free_oh;
    logic [CAPACITY-1:0] slot;
    logic [RW-1:0]       hit_rank;
    logic                any_match;
    logic                cap_zero;
    logic                full;
    logic                is_hit;
    logic                do_insert;
    logic [COST_W-1:0]   inc;
    logic [COST_W:0]     sum;

    assign key      = i_req.key[TW-1:0];
    assign cap_zero = (r_cap == '0);
    // effective capacity is min(register, CAPACITY)
    assign full     = (CMPW'(r_fill) >= CMPW'(r_cap)) || (CMPW'(r_fill) >= CMPW'(CAPACITY));

    always_comb begin
        hit_rank = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            match[i]  = r_valid[i] && (r_tag[i] == key);
            victim[i] = r_valid[i] && (CMPW'(r_rank[i]) == (CMPW'(r_fill) - CMPW'(1)));
            if (match[i]) begin
                hit_rank = hit_rank | r_rank[i];
            end
        end
    end

    assign any_match = |match;
    // lowest-index free entry
    assign free_oh   = ~r_valid & (r_valid + CAPACITY'(1));
    assign slot      = full ? victim : free_oh;
    assign is_hit    = !cap_zero && any_match;
    assign do_insert = !cap_zero && !any_match;

    assign inc    = is_hit ? HIT_COST : MISS_COST;
    assign sum    = {1'b0, r_cost} + {1'b0, inc};
    assign n_cost = sum[COST_W] ? '1 : sum[COST_W-1:0];

    always_comb begin
        n_valid = r_valid;
        n_fill  = r_fill;
        for (int i = 0; i < CAPACITY; i++) begin
            n_rank[i] = r_rank[i];
            if (is_hit) begin
                if (match[i]) begin
                    n_rank[i] = '0;
                end else if (r_valid[i] && (r_rank[i] < hit_rank)) begin
                    n_rank[i] = r_rank[i] + RW'(1);
                end
            end else if (do_insert) begin
                if (slot[i]) begin
                    n_rank[i]  = '0;
                    n_valid[i] = 1'b1;
                end else if (r_valid[i]) begin
                    n_rank[i] = r_rank[i] + RW'(1);
                end
            end
        end
        if (do_insert && !full) begin
            n_fill = r_fill + FW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_fill  <= '0;
            r_cap   <= CAP_RESET_VAL;
            r_cost  <= '0;
            r_hit   <= 1'b0;
        end else if (i_cfg_we) begin
            // new capacity flushes the cache, cost is kept
            r_cap   <= i_cfg_data;
            r_valid <= '0;
            r_fill  <= '0;
        end else if (i_req.step) begin
            r_valid <= n_valid;
            r_fill  <= n_fill;
            r_cost  <= n_cost;
            r_hit   <= is_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.step) begin
            for (int i = 0; i < CAPACITY; i++) begin
                r_rank[i] <= n_rank[i];
                if (do_insert && slot[i]) begin
                    r_tag[i] <= key;
                end
            end
        end
    end

    assign o_rsp.hit  = r_hit;
    assign o_rsp.cost = r_cost;

endmodule

[src/lru_cache_hit_cost_top.sv]
// ----------------------------------------------------------------------------
// lru_cache_hit_cost_top: LRU key cache with running access cost
// Stream in keys, stream out hit flag and saturating cost per key.
// ----------------------------------------------------------------------------
// Usage
//   Slave stream carries one key word per transfer (64 bits, byte 0 low).
//   Each byte A-Z is folded to a-z (bytes past KEY_BYTES are dropped) and the
//   folded key is looked up in a CAPACITY-entry fully associative cache.
//   Master stream returns one word per key: hit flag and running cost
//   (+1 per hit, +5 per miss, saturating at 2^32-1).
//   The accept edge loads the key into the input register; its lookup then
//   loads the result register once that is free or being drained.
//   Throughput: 1 word per cycle while m_axis_tready is high; tag compare and
//   rank update over all entries are combinational, so keys can follow back to back.
//   Stall: while the result waits, one more key is held in the input register;
//   s_axis_tready drops only when both registers are occupied.
//   Config: i_cfg_we writes cache_capacity (0 disables caching, above
//   CAPACITY acts as CAPACITY); every write flushes all entries and keeps
//   the cost. Write only while the block is idle.
//   Reset: cache empty, cost zero, capacity 16, no results pending.
// ----------------------------------------------------------------------------
module lru_cache_hit_cost_top
    import lruc_pkg::*;
#(
    parameter int CAPACITY  = 16,
    parameter int KEY_BYTES = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // config
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_data,   // cache_capacity
    // key stream
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [63:0]      s_axis_tdata, // [63:0] key
    // result stream
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [39:0]      m_axis_tdata  // [0] hit, [32:1] total_cost, [39:33] zero
);

    localparam int TW = 8 * KEY_BYTES;

    logic          r_in_valid;
    logic [TW-1:0] r_key;
    logic          r_out_valid;

    logic          accept_in;
    logic          step;
    t_lruc_req     req;
    t_lruc_rsp     rsp;
    logic [KEY_W-1:0] folded;

    // lookup runs when the result register is free or being drained
    assign step          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || step;
    assign accept_in     = s_axis_tvalid && s_axis_tready;
    assign folded        = fold_key(s_axis_tdata);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept_in) begin
                r_in_valid <= 1'b1;
            end else if (step) begin
                r_in_valid <= 1'b0;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_key <= folded[TW-1:0];
        end
    end

    assign req.step = step;
    assign req.key  = KEY_W'(r_key);

    lruc_core #(
        .CAPACITY  (CAPACITY),
        .KEY_BYTES (KEY_BYTES)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_req      (req),
        .o_rsp      (rsp)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, rsp.cost, rsp.hit};

    // ready low only with both stages full
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_in_valid && r_out_valid))
        else $error("tready low with a free stage");

    // a lookup always leaves a result pending
    a_step_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> m_axis_tvalid)
        else $error("lookup without result");

    // running cost never decreases
    a_cost_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> (rsp.cost >= $past(rsp.cost)))
        else $error("cost decreased");

    // cost holds while the result stalls
    a_cost_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(rsp.cost))
        else $error("cost changed under stall");

endmodule
